/* rtl/assert_macros.svh */
// assertion macros included by the decoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, cond, prop)
`define ASSERT_NEXT(label, clk, rst, cond, prop)
`endif

`endif

/* rtl/srld_pkg.sv */
// types and constants of the sprite run length decoder
package srld_pkg;

  localparam int unsigned SIDE_PIXELS_DEF = 32;
  localparam int unsigned RUN_W = 11;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned OUT_DATA_W = 48;
  localparam int unsigned OUT_USER_W = 2;

  typedef enum logic [2:0] {
    PH_CLR_LO = 3'd0,
    PH_CLR_HI = 3'd1,
    PH_COL_LO = 3'd2,
    PH_COL_HI = 3'd3,
    PH_RED    = 3'd4,
    PH_GREEN  = 3'd5,
    PH_BLUE   = 3'd6
  } phase_t;

  typedef struct packed {
    logic [RUN_W-1:0]   run_start;
    logic [RUN_W-1:0]   run_length;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               opaque;
    logic               sprite_done;
    logic               has_color;
  } run_t;

endpackage

/* rtl/sprite_run_length_decoder.sv */
// sprite run length decoder: compressed bytes in, pixel runs out
// output: a run is registered into the output queue when the byte that completes it is accepted
// throughput: one byte per cycle; a last byte that also completes a run yields two
// results, and the four-entry output queue stalls input only when it lacks two free slots
// reset: synchronous, clears the header phase, counters, color flag and output queue
`include "assert_macros.svh"

module sprite_run_length_decoder #(
  parameter int unsigned SIDE_PIXELS = srld_pkg::SIDE_PIXELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // data_byte
  input  logic                            s_axis_tlast,  // last_byte
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // run_start, run_length, red, green, blue, zero pad
  output logic [srld_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic [srld_pkg::OUT_USER_W-1:0] m_axis_tuser,  // opaque, has_color
  output logic                            m_axis_tlast   // sprite_done
);
  import srld_pkg::*;

  localparam int unsigned TOTAL  = SIDE_PIXELS * SIDE_PIXELS;
  localparam int unsigned IDX_W  = $clog2(TOTAL + 1);
  localparam int unsigned IW     = (IDX_W > RUN_W) ? IDX_W : RUN_W;
  localparam int unsigned CW     = (IW > COUNT_W) ? IW : COUNT_W;
  localparam int unsigned DEPTH  = 4;
  localparam int unsigned PTR_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned PAD_W  = OUT_DATA_W - 2 * RUN_W - 3 * COLOR_W;

  phase_t                   phase, phase_next;
  logic [COUNT_W-1:0]       clear_count, clear_count_next;
  logic [COUNT_W-1:0]       color_left, color_left_next;
  logic [2*COLOR_W-1:0]     partial_rgb, partial_rgb_next;
  logic [IW-1:0]            write_index, write_index_next;
  logic                     seen_color, seen_color_next;

  run_t                     queue [DEPTH];
  logic [PTR_W-1:0]         wr_ptr, rd_ptr;
  logic [CNT_W-1:0]         count;

  logic                     accept, pop, active;
  logic                     step_vld;
  run_t                     step_run, close_run;
  logic [CW-1:0]            room, clear_ext, len;
  logic [IW-1:0]            rest;
  logic [1:0]               push_n;

  assign accept = s_axis_tvalid & s_axis_tready;
  assign pop    = m_axis_tvalid & m_axis_tready;
  assign active = write_index < IW'(TOTAL);

  assign room      = CW'(TOTAL) - CW'(write_index);
  assign clear_ext = CW'(clear_count);
  assign len       = (clear_ext < room) ? clear_ext : room;

  // next phase
  always_comb begin
    phase_next = phase;
    if (active) begin
      unique case (phase)
        PH_CLR_HI: phase_next = PH_COL_LO;
        PH_COL_LO: phase_next = PH_COL_HI;
        PH_COL_HI: begin
          phase_next = ({s_axis_tdata, color_left[7:0]} != '0) ? PH_RED : PH_CLR_LO;
        end
        PH_RED:    phase_next = PH_GREEN;
        PH_GREEN:  phase_next = PH_BLUE;
        PH_BLUE:   phase_next = (color_left != COUNT_W'(1)) ? PH_RED : PH_CLR_LO;
        default:   phase_next = PH_CLR_HI;
      endcase
    end
    if (s_axis_tlast) phase_next = PH_CLR_LO;
  end

  // counters and results
  always_comb begin
    clear_count_next = clear_count;
    color_left_next  = color_left;
    partial_rgb_next = partial_rgb;
    write_index_next = write_index;
    seen_color_next  = seen_color;
    step_vld         = 1'b0;
    step_run         = '0;
    step_run.run_start = write_index[RUN_W-1:0];
    if (active) begin
      unique case (phase)
        PH_CLR_HI: clear_count_next = {s_axis_tdata, clear_count[7:0]};
        PH_COL_LO: color_left_next = COUNT_W'(s_axis_tdata);
        PH_COL_HI: begin
          color_left_next = {s_axis_tdata, color_left[7:0]};
          if (len != '0) begin
            step_vld            = 1'b1;
            step_run.run_length = len[RUN_W-1:0];
            write_index_next    = write_index + IW'(len);
          end
          if ({s_axis_tdata, color_left[7:0]} != '0) seen_color_next = 1'b1;
        end
        PH_RED:    partial_rgb_next = {8'h00, s_axis_tdata};
        PH_GREEN:  partial_rgb_next = {s_axis_tdata, partial_rgb[7:0]};
        PH_BLUE: begin
          step_vld            = 1'b1;
          step_run.run_length = RUN_W'(1);
          step_run.red        = partial_rgb[7:0];
          step_run.green      = partial_rgb[15:8];
          step_run.blue       = s_axis_tdata;
          step_run.opaque     = 1'b1;
          write_index_next    = write_index + IW'(1);
          color_left_next     = color_left - COUNT_W'(1);
        end
        default:   clear_count_next = COUNT_W'(s_axis_tdata);
      endcase
    end

    rest                  = IW'(TOTAL) - write_index_next;
    close_run             = '0;
    close_run.run_start   = write_index_next[RUN_W-1:0];
    close_run.run_length  = rest[RUN_W-1:0];
    close_run.sprite_done = 1'b1;
    close_run.has_color   = seen_color_next;

    if (s_axis_tlast) begin
      clear_count_next = '0;
      color_left_next  = '0;
      partial_rgb_next = '0;
      write_index_next = '0;
      seen_color_next  = 1'b0;
    end
    push_n = {1'b0, step_vld} + {1'b0, s_axis_tlast};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_CLR_LO;
      clear_count <= '0;
      color_left  <= '0;
      partial_rgb <= '0;
      write_index <= '0;
      seen_color  <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      clear_count <= clear_count_next;
      color_left  <= color_left_next;
      partial_rgb <= partial_rgb_next;
      write_index <= write_index_next;
      seen_color  <= seen_color_next;
    end
  end

  // output queue payload
  always_ff @(posedge clk) begin
    if (accept) begin
      if (step_vld) begin
        queue[wr_ptr] <= step_run;
      end
      if (s_axis_tlast) begin
        queue[wr_ptr + PTR_W'(step_vld)] <= close_run;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) wr_ptr <= wr_ptr + PTR_W'(push_n);
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      count <= count + (accept ? CNT_W'(push_n) : '0) - CNT_W'(pop);
    end
  end

  assign s_axis_tready = count <= CNT_W'(DEPTH - 2);
  assign m_axis_tvalid = count != '0;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, queue[rd_ptr].blue, queue[rd_ptr].green,
                          queue[rd_ptr].red, queue[rd_ptr].run_length,
                          queue[rd_ptr].run_start};
  assign m_axis_tuser  = {queue[rd_ptr].has_color, queue[rd_ptr].opaque};
  assign m_axis_tlast  = queue[rd_ptr].sprite_done;

  `ASSERT_IMPLIES(a_queue_bound, clk, rst, 1'b1, count <= CNT_W'(DEPTH))
  `ASSERT_IMPLIES(a_index_bound, clk, rst, 1'b1, write_index <= IW'(TOTAL))
  `ASSERT_NEXT(a_last_clears, clk, rst, accept && s_axis_tlast, write_index == '0 && phase == PH_CLR_LO && !seen_color)
  `ASSERT_IMPLIES(a_opaque_single, clk, rst, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[2*RUN_W-1:RUN_W] == RUN_W'(1) && !m_axis_tlast)

endmodule
